/* hw/rtl/lbst_pkg.sv */
// Package for the L1-bound soft-threshold projection: widths, beat types, codes and FSM types.
`default_nettype none
package lbst_pkg;

    localparam int LBST_MAX_LEN = 64;

    localparam int SAMPLE_W   = 24;
    localparam int PROJ_W     = 18;
    localparam int POS_W      = 6;
    localparam int TGT_W      = 20;
    localparam int TOL_W      = 16;
    localparam int ITER_W     = 10;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_W        = 17;
    localparam int L1_W       = 23;
    localparam int ERR_W      = 25;
    localparam int PROD_W     = 48;
    localparam int SUM_W      = 54;
    localparam int ROOT_W     = 28;
    localparam int REM_W      = 28;
    localparam int DVD_W      = 41;
    localparam int DIV_STEPS  = 17;
    localparam int SH_W       = 5;

    localparam logic [TGT_W-1:0]  L1_TARGET_RST = 20'd131072;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 16'd66;
    localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 10'd100;
    localparam logic [Q_W-1:0]    Q_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_TARGET       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_element;
    } in_beat_t;

    typedef struct packed {
        logic signed [PROJ_W-1:0] projected;
        logic [POS_W-1:0]         position;
        logic                     end_of_vector;
        logic                     not_converged;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_A_RD, ST_A_ACC, ST_A_CHK, ST_NORM, ST_B_RD, ST_B_SQ, ST_B_ACC,
        ST_SQRT, ST_C_RD, ST_C_LD, ST_C_DIV, ST_C_WR, ST_P0_CHK, ST_K_RDI, ST_K_LATI,
        ST_K_RDJ, ST_K_CNT, ST_K_EVAL, ST_BIS, ST_MID, ST_EVAL, ST_O_RD, ST_O_LD,
        ST_O_WAIT
    } state_t;

    typedef enum logic [4:0] {
        OP_LOAD, OP_A_RD, OP_A_ACC, OP_A_CHK, OP_NORM, OP_B_RD, OP_B_SQ, OP_B_ACC,
        OP_SQRT, OP_C_RD, OP_C_LD, OP_C_DIV, OP_C_WR, OP_P0_CHK, OP_K_RDI, OP_K_LATI,
        OP_K_RDJ, OP_K_CNT, OP_K_EVAL, OP_BIS, OP_MID, OP_EVAL, OP_O_RD, OP_O_LD,
        OP_O_WAIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic phase;
    } lbst_cmd_t;

    typedef struct packed {
        logic load_done;
        logic last;
        logic m_zero;
        logic norm_done;
        logic sqrt_last;
        logic div_last;
        logic j_last;
        logic p0_go;
        logic eval_stop;
        logic out_taken;
    } lbst_status_t;

endpackage
`default_nettype wire

/* hw/rtl/lbst_stream_if.sv */
// Valid/ready stream interface that carries one beat of a given payload type.
`default_nettype none
interface lbst_stream_if #(parameter type beat_t = logic);
    logic  valid;
    logic  ready;
    beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lbst_ctrl.sv */
// Controller state machine that sequences loading, projection passes, selection, bisection and output.
`default_nettype none
module lbst_ctrl
    import lbst_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lbst_status_t status,
    output lbst_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (status.load_done)
                begin
                    state_next = ST_A_RD;
                    phase_next = 1'b0;
                end
            end
            ST_A_RD:   state_next = ST_A_ACC;
            ST_A_ACC:  state_next = status.last ? ST_A_CHK : ST_A_RD;
            ST_A_CHK:
            begin
                if (status.m_zero)
                    state_next = phase_reg ? ST_EVAL : ST_P0_CHK;
                else
                    state_next = ST_NORM;
            end
            ST_NORM:   state_next = status.norm_done ? ST_B_RD : ST_NORM;
            ST_B_RD:   state_next = ST_B_SQ;
            ST_B_SQ:   state_next = ST_B_ACC;
            ST_B_ACC:  state_next = status.last ? ST_SQRT : ST_B_RD;
            ST_SQRT:   state_next = status.sqrt_last ? ST_C_RD : ST_SQRT;
            ST_C_RD:   state_next = ST_C_LD;
            ST_C_LD:   state_next = ST_C_DIV;
            ST_C_DIV:  state_next = status.div_last ? ST_C_WR : ST_C_DIV;
            ST_C_WR:
            begin
                if (status.last)
                    state_next = phase_reg ? ST_EVAL : ST_P0_CHK;
                else
                    state_next = ST_C_RD;
            end
            ST_P0_CHK: state_next = status.p0_go ? ST_K_RDI : ST_O_RD;
            ST_K_RDI:  state_next = ST_K_LATI;
            ST_K_LATI: state_next = ST_K_RDJ;
            ST_K_RDJ:  state_next = ST_K_CNT;
            ST_K_CNT:  state_next = status.j_last ? ST_K_EVAL : ST_K_RDJ;
            ST_K_EVAL: state_next = status.last ? ST_BIS : ST_K_RDI;
            ST_BIS:    state_next = ST_MID;
            ST_MID:
            begin
                state_next = ST_A_RD;
                phase_next = 1'b1;
            end
            ST_EVAL:   state_next = status.eval_stop ? ST_O_RD : ST_MID;
            ST_O_RD:   state_next = ST_O_LD;
            ST_O_LD:   state_next = ST_O_WAIT;
            ST_O_WAIT:
            begin
                if (status.out_taken)
                    state_next = status.last ? ST_LOAD : ST_O_RD;
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd.phase = phase_reg;
        unique case (state_reg)
            ST_LOAD:   cmd.op = OP_LOAD;
            ST_A_RD:   cmd.op = OP_A_RD;
            ST_A_ACC:  cmd.op = OP_A_ACC;
            ST_A_CHK:  cmd.op = OP_A_CHK;
            ST_NORM:   cmd.op = OP_NORM;
            ST_B_RD:   cmd.op = OP_B_RD;
            ST_B_SQ:   cmd.op = OP_B_SQ;
            ST_B_ACC:  cmd.op = OP_B_ACC;
            ST_SQRT:   cmd.op = OP_SQRT;
            ST_C_RD:   cmd.op = OP_C_RD;
            ST_C_LD:   cmd.op = OP_C_LD;
            ST_C_DIV:  cmd.op = OP_C_DIV;
            ST_C_WR:   cmd.op = OP_C_WR;
            ST_P0_CHK: cmd.op = OP_P0_CHK;
            ST_K_RDI:  cmd.op = OP_K_RDI;
            ST_K_LATI: cmd.op = OP_K_LATI;
            ST_K_RDJ:  cmd.op = OP_K_RDJ;
            ST_K_CNT:  cmd.op = OP_K_CNT;
            ST_K_EVAL: cmd.op = OP_K_EVAL;
            ST_BIS:    cmd.op = OP_BIS;
            ST_MID:    cmd.op = OP_MID;
            ST_EVAL:   cmd.op = OP_EVAL;
            ST_O_RD:   cmd.op = OP_O_RD;
            ST_O_LD:   cmd.op = OP_O_LD;
            ST_O_WAIT: cmd.op = OP_O_WAIT;
            default:   cmd.op = OP_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lbst_datapath.sv */
// Datapath: element and result memories, thresholding, square root, division and bisection registers.
`default_nettype none
module lbst_datapath
    import lbst_pkg::*;
#(
    parameter int MAX_LEN = LBST_MAX_LEN
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lbst_cmd_t              cmd,
    output lbst_status_t                status,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    lbst_stream_if.sink                 samples,
    lbst_stream_if.source               results
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [SAMPLE_W-1:0] store_mem [MAX_LEN];
    logic [Q_W-1:0]      q_mem [MAX_LEN];

    logic [SAMPLE_W-1:0] rd_reg;
    logic [Q_W-1:0]      qrd_reg;
    logic [AW-1:0]       addr;
    logic                in_ready;
    logic                in_accept;
    logic                store_wr;
    logic                q_wr;

    logic [AW-1:0]       count_reg, count_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       j_reg, j_next;
    logic                out_vld_reg, out_vld_next;
    logic [TGT_W-1:0]    target_reg, target_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [ITER_W-1:0]   limit_reg, limit_next;
    logic [SAMPLE_W-1:0] low_reg, low_next;
    logic [SAMPLE_W-1:0] high_reg, high_next;
    logic [SAMPLE_W-1:0] mid_reg, mid_next;
    logic [ITER_W-1:0]   step_reg, step_next;

    logic [SAMPLE_W-1:0] m_reg, m_next;
    logic [SAMPLE_W-1:0] mn_reg, mn_next;
    logic [SH_W-1:0]     sh_reg, sh_next;
    logic                zero_reg, zero_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]    v_reg, v_next;
    logic [SUM_W-1:0]    r_reg, r_next;
    logic [SUM_W-1:0]    b_reg, b_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]      dlo_reg, dlo_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [SH_W-1:0]     dcnt_reg, dcnt_next;
    logic [L1_W-1:0]     l1_reg, l1_next;
    logic [AW-1:0]       s_reg, s_next;
    logic [SAMPLE_W-1:0] magi_reg, magi_next;
    logic [CW-1:0]       gt_reg, gt_next;
    logic [CW-1:0]       eq_reg, eq_next;
    logic [SAMPLE_W-1:0] kth_reg, kth_next;
    logic                nc_reg, nc_next;
    out_beat_t           out_reg, out_next;

    logic [SAMPLE_W-1:0] mag_rd;
    logic [SAMPLE_W-1:0] t_cur;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic [ROOT_W-1:0]   root;
    logic                idx_last;
    logic [SUM_W:0]      rb;
    logic [REM_W:0]      div_try;
    logic [DVD_W-1:0]    dvd;
    logic [2*TGT_W-1:0]  tgt_sq;
    logic [7:0]          sq_hi;
    logic [8:0]          s_raw;
    logic [8:0]          n_m1;
    logic signed [ERR_W-1:0] err;
    logic                err_hi;
    logic                err_lo;
    logic [SAMPLE_W-1:0] m_m1;
    logic [PROJ_W-1:0]   pv;

    // Magnitude of the stored sample held in the registered memory read.
    assign mag_rd   = rd_reg[SAMPLE_W-1] ? (~rd_reg + 1'b1) : rd_reg;
    assign t_cur    = cmd.phase ? mid_reg : '0;
    assign y        = (mag_rd > t_cur) ? (mag_rd - t_cur) : '0;
    assign z        = y << sh_reg;
    assign root     = r_reg[ROOT_W-1:0];
    assign idx_last = (CW'(idx_reg) == n_reg - 1'b1);
    assign rb       = {1'b0, r_reg} + {1'b0, b_reg};
    assign div_try  = {rem_reg, dlo_reg[Q_W-1]};
    assign dvd      = {1'b0, z, 16'b0} + DVD_W'(root >> 1);
    assign tgt_sq   = (2*TGT_W)'(target_reg) * (2*TGT_W)'(target_reg);
    assign sq_hi    = tgt_sq[2*TGT_W-1:32];
    assign s_raw    = (sq_hi == 8'd0) ? 9'd0 : 9'({1'b0, sq_hi} - 9'd1);
    assign n_m1     = 9'(n_reg - 1'b1);
    assign err      = $signed({2'b0, l1_reg}) - $signed({5'b0, target_reg});
    assign err_hi   = err > $signed({9'b0, tol_reg});
    assign err_lo   = err < -$signed({9'b0, tol_reg});
    assign m_m1     = m_reg - 1'b1;
    assign pv       = {1'b0, (zero_reg ? '0 : qrd_reg)};

    assign in_ready  = (cmd.op == OP_LOAD);
    assign in_accept = in_ready && samples.valid;
    assign store_wr  = in_accept;
    assign q_wr      = (cmd.op == OP_C_WR);

    assign samples.ready = in_ready;
    assign results.valid = out_vld_reg;
    assign results.data  = out_reg;

    always_comb
    begin
        case (cmd.op)
            OP_LOAD:  addr = count_reg;
            OP_K_RDJ: addr = j_reg;
            default:  addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_mem[count_reg] <= samples.data.sample;
        if (q_wr)
            q_mem[idx_reg] <= q_reg;
        rd_reg  <= store_mem[addr];
        qrd_reg <= q_mem[addr];
    end

    always_comb
    begin
        status.load_done = in_accept &&
            (samples.data.final_element || (count_reg == AW'(MAX_LEN - 1)));
        status.last      = idx_last;
        status.m_zero    = (m_reg == '0);
        status.norm_done = mn_reg[SAMPLE_W-1];
        status.sqrt_last = (b_reg == SUM_W'(1));
        status.div_last  = (dcnt_reg == SH_W'(DIV_STEPS - 1));
        status.j_last    = (CW'(j_reg) == n_reg - 1'b1);
        status.p0_go     = !zero_reg && ({{(TGT_W){1'b0}}, l1_reg} > 43'(target_reg));
        status.eval_stop = !(err_hi || err_lo) || (step_reg >= limit_reg);
        status.out_taken = out_vld_reg && results.ready;
    end

    always_comb
    begin
        count_next   = count_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        out_vld_next = out_vld_reg;
        target_next  = target_reg;
        tol_next     = tol_reg;
        limit_next   = limit_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        step_next    = step_reg;
        m_next       = m_reg;
        mn_next      = mn_reg;
        sh_next      = sh_reg;
        zero_next    = zero_reg;
        prod_next    = prod_reg;
        v_next       = v_reg;
        r_next       = r_reg;
        b_next       = b_reg;
        rem_next     = rem_reg;
        dlo_next     = dlo_reg;
        q_next       = q_reg;
        dcnt_next    = dcnt_reg;
        l1_next      = l1_reg;
        s_next       = s_reg;
        magi_next    = magi_reg;
        gt_next      = gt_reg;
        eq_next      = eq_reg;
        kth_next     = kth_reg;
        nc_next      = nc_reg;
        out_next     = out_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_L1_TARGET:       target_next = cfg_data[TGT_W-1:0];
                CFG_TOLERANCE:       tol_next    = cfg_data[TOL_W-1:0];
                CFG_ITERATION_LIMIT: limit_next  = cfg_data[ITER_W-1:0];
                default:             ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                if (in_accept)
                begin
                    if (status.load_done)
                    begin
                        count_next = '0;
                        n_next     = CW'(count_reg) + 1'b1;
                        idx_next   = '0;
                    end
                    else
                        count_next = count_reg + 1'b1;
                end
            end
            OP_A_ACC:
            begin
                if (idx_reg == '0)
                    m_next = y;
                else if (y > m_reg)
                    m_next = y;
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            OP_A_CHK:
            begin
                zero_next = (m_reg == '0);
                l1_next   = '0;
                mn_next   = m_reg;
                sh_next   = '0;
                v_next    = '0;
            end
            OP_NORM:
            begin
                if (!mn_reg[SAMPLE_W-1])
                begin
                    mn_next = mn_reg << 1;
                    sh_next = sh_reg + 1'b1;
                end
            end
            OP_B_SQ:
                prod_next = PROD_W'(z) * PROD_W'(z);
            OP_B_ACC:
            begin
                v_next   = v_reg + SUM_W'(prod_reg);
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
                if (idx_last)
                begin
                    r_next = '0;
                    b_next = SUM_W'(1) << (SUM_W - 2);
                end
            end
            OP_SQRT:
            begin
                if ({1'b0, v_reg} >= rb)
                begin
                    v_next = v_reg - rb[SUM_W-1:0];
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                    r_next = r_reg >> 1;
                b_next = b_reg >> 2;
            end
            OP_C_LD:
            begin
                rem_next  = REM_W'(dvd[DVD_W-1:DIV_STEPS]);
                dlo_next  = dvd[DIV_STEPS-1:0];
                q_next    = '0;
                dcnt_next = '0;
            end
            OP_C_DIV:
            begin
                if (div_try >= {1'b0, root})
                begin
                    rem_next = REM_W'(div_try - {1'b0, root});
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_try[REM_W-1:0];
                    q_next   = {q_reg[Q_W-2:0], 1'b0};
                end
                dlo_next  = dlo_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
            end
            OP_C_WR:
            begin
                l1_next  = l1_reg + L1_W'(q_reg);
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            OP_P0_CHK:
            begin
                nc_next  = 1'b0;
                kth_next = '0;
                s_next   = (s_raw > n_m1) ? AW'(n_m1) : AW'(s_raw);
            end
            OP_K_LATI:
            begin
                magi_next = mag_rd;
                j_next    = '0;
                gt_next   = '0;
                eq_next   = '0;
            end
            OP_K_CNT:
            begin
                if (mag_rd > magi_reg)
                    gt_next = gt_reg + 1'b1;
                else if (mag_rd == magi_reg)
                    eq_next = eq_reg + 1'b1;
                j_next = status.j_last ? '0 : j_reg + 1'b1;
            end
            OP_K_EVAL:
            begin
                if ((gt_reg <= CW'(s_reg)) &&
                    ((CW+1)'(s_reg) < (CW+1)'(gt_reg) + (CW+1)'(eq_reg)))
                    kth_next = magi_reg;
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            OP_BIS:
            begin
                low_next  = '0;
                high_next = (kth_reg < m_m1) ? kth_reg : m_m1;
                step_next = '0;
            end
            OP_MID:
                mid_next = SAMPLE_W'(({1'b0, low_reg} + {1'b0, high_reg}) >> 1);
            OP_EVAL:
            begin
                if (status.eval_stop)
                    nc_next = err_hi || err_lo;
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (err_hi)
                        low_next = mid_reg;
                    else
                        high_next = mid_reg;
                end
            end
            OP_O_LD:
            begin
                out_next.projected     = rd_reg[SAMPLE_W-1] ? -$signed(pv) : $signed(pv);
                out_next.position      = POS_W'(idx_reg);
                out_next.end_of_vector = idx_last;
                out_next.not_converged = nc_reg;
                out_vld_next           = 1'b1;
            end
            OP_O_WAIT:
            begin
                if (status.out_taken)
                begin
                    out_vld_next = 1'b0;
                    idx_next     = idx_last ? '0 : idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            n_reg       <= '0;
            idx_reg     <= '0;
            j_reg       <= '0;
            out_vld_reg <= 1'b0;
            target_reg  <= L1_TARGET_RST;
            tol_reg     <= TOLERANCE_RST;
            limit_reg   <= ITER_LIMIT_RST;
            low_reg     <= '0;
            high_reg    <= '0;
            mid_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            n_reg       <= n_next;
            idx_reg     <= idx_next;
            j_reg       <= j_next;
            out_vld_reg <= out_vld_next;
            target_reg  <= target_next;
            tol_reg     <= tol_next;
            limit_reg   <= limit_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            mid_reg     <= mid_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        mn_reg   <= mn_next;
        sh_reg   <= sh_next;
        zero_reg <= zero_next;
        prod_reg <= prod_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        dlo_reg  <= dlo_next;
        q_reg    <= q_next;
        dcnt_reg <= dcnt_next;
        l1_reg   <= l1_next;
        s_reg    <= s_next;
        magi_reg <= magi_next;
        gt_reg   <= gt_next;
        eq_reg   <= eq_next;
        kth_reg  <= kth_next;
        nc_reg   <= nc_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_vld_reg))
        else $error("input taken while a result beat is pending");
    a_rem_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_C_DIV) |-> ({1'b0, rem_reg} < {1'b0, root}))
        else $error("division remainder not below the root");
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_C_WR) |-> (q_reg <= Q_ONE))
        else $error("normalized magnitude above one");
    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EVAL) |-> ((low_reg <= mid_reg) && (mid_reg <= high_reg)))
        else $error("bisection midpoint outside its bracket");
`endif

endmodule
`default_nettype wire

/* hw/rtl/l1_bound_soft_threshold_projection.sv */
// Top level of the L1-bound soft-threshold projection: controller and datapath.
// Load takes one beat per cycle. After the last beat, each projection pass is dominated by
// the per-element divider, the order selection compares every pair of elements, and the
// block runs one pass at t = 0 plus one per bisection step (at most iteration_limit + 1).
// Output beats go one at a time: the next is read only after the last one is taken.
// Reset: configuration returns to its defaults and the controller waits for a new vector.
`default_nettype none
module l1_bound_soft_threshold_projection
    import lbst_pkg::*;
#(
    parameter int MAX_LEN = LBST_MAX_LEN
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    lbst_stream_if.sink               samples,
    lbst_stream_if.source             results
);

    // The controller only sequences; every register that holds data or counts
    // elements sits in the datapath, which reports back through the status struct.
    lbst_cmd_t    cmd;
    lbst_status_t status;

    lbst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath owns both memories: raw samples for the thresholding sweeps and
    // the sign at output, and the normalized magnitudes from the latest pass.
    lbst_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .results   (results)
    );

endmodule
`default_nettype wire
